// ===== rtl/core/fblx_pkg.sv =====
// ----------------------------------------------------------------------------
// Flow blocklist package
// Shared types, result codes and constants for the flow blocklist block.
// ----------------------------------------------------------------------------
`default_nettype none

package fblx_pkg;

  localparam int FBLX_TABLE_DEPTH = 32;

  localparam int KEY_W    = 64;
  localparam int EXPIRY_W = 33;
  localparam int IFACE_W  = 32;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 16;
  localparam int KIND_W   = 3;
  localparam int PADDR_W  = 3;

  localparam logic [DUR_W-1:0]   DURATION_RESET = 16'd60;
  localparam logic [KEY_W-1:0]   MIX_MUL        = 64'hff51afd7ed558ccd;
  localparam int                 MIX_SHIFT      = 33;

  localparam logic [PADDR_W-1:0] ADDR_BLOCK_DURATION = 3'd0;

  localparam logic [KIND_W-1:0] KIND_INSERTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFRESHED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SWEEP_DONE = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [EXPIRY_W-1:0] expiry;
    logic [IFACE_W-1:0]  iface;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/fblx_ifs.sv =====
// ----------------------------------------------------------------------------
// Flow blocklist channel interfaces
// Valid/ready channels for block and sweep events and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fblx_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        matched;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [31:0] iface_index;
  logic [31:0] now_seconds;

  modport source (output valid, mode, matched, src_addr, dst_addr, dst_port, protocol,
                  iface_index, now_seconds, input ready);
  modport sink   (input valid, mode, matched, src_addr, dst_addr, dst_port, protocol,
                  iface_index, now_seconds, output ready);
endinterface

interface fblx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] flow_key;
  logic [31:0] out_iface;
  logic        last;

  modport source (output valid, kind, flow_key, out_iface, last, input ready);
  modport sink   (input valid, kind, flow_key, out_iface, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fblx_hash.sv =====
// ----------------------------------------------------------------------------
// Flow key hash unit
// Shift/xor/multiply mix; the 64-bit multiply runs as three 32x32 products.
// ----------------------------------------------------------------------------
`default_nettype none

module fblx_hash (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [31:0]                   src_addr,
  input  wire [31:0]                   dst_addr,
  input  wire [15:0]                   dst_port,
  input  wire [7:0]                    protocol,
  output logic                         done,
  output logic [fblx_pkg::KEY_W-1:0]   key
);
  import fblx_pkg::*;

  logic [KEY_W-1:0] seed;
  logic [KEY_W-1:0] v_r;
  logic [KEY_W-1:0] acc_r, acc_nxt;
  logic [KEY_W-1:0] key_r;
  logic [1:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;

  always_comb begin
    seed = {src_addr, dst_addr} ^ {32'd0, dst_port, 8'd0, protocol};
    seed = seed ^ (seed >> MIX_SHIFT);
  end

  always_comb begin
    mul_a = v_r[31:0];
    mul_b = MIX_MUL[31:0];
    case (step_r)
      2'd1:    mul_a = v_r[63:32];
      2'd2:    mul_b = MIX_MUL[63:32];
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    case (step_r)
      2'd0:    acc_nxt = prod;
      2'd1,
      2'd2:    acc_nxt = acc_r + {prod[31:0], 32'd0};
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= seed;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
      if (step_r == 2'd3) begin
        key_r <= acc_r ^ (acc_r >> MIX_SHIFT);
      end
    end
  end

  assign done = done_r;
  assign key  = key_r;

endmodule

`default_nettype wire

// ===== rtl/core/fblx_cell.sv =====
// ----------------------------------------------------------------------------
// Flow table cell
// One table entry; passes its entry to the next cell of the ring on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fblx_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    shift_en,
  input  wire fblx_pkg::entry_t  entry_in,
  output fblx_pkg::entry_t       entry_out
);
  import fblx_pkg::*;

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign entry_out = entry_r;

endmodule

`default_nettype wire

// ===== rtl/core/flow_blocklist_with_expiry_top.sv =====
// ----------------------------------------------------------------------------
// Flow blocklist with expiry
// An ignored verdict gives its result in the cycle after the transfer; a block
// verdict hashes the key, steps once through all TABLE_DEPTH ring cells and
// then gives its result; a sweep steps once through the ring, each release
// step waiting on the result side. One item is taken at a time, only when idle.
// Reset clears every entry to zero and sets block_duration to 60.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_blocklist_with_expiry_top #(
  parameter int TABLE_DEPTH = fblx_pkg::FBLX_TABLE_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst_n,
  fblx_in_if.sink                       in_ch,
  fblx_out_if.source                    out_ch,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [fblx_pkg::PADDR_W-1:0]   paddr,
  input  wire [31:0]                    pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fblx_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_SCAN, S_DONE} state_t;

  state_t               state_r;
  logic [DUR_W-1:0]     dur_r;
  logic                 mode_r;
  logic [TIME_W-1:0]    now_r;
  logic [IFACE_W-1:0]   iface_r;
  logic [EXPIRY_W-1:0]  exp_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 found_r;
  logic [KIND_W-1:0]    kind_r;

  logic                 ov_r;
  logic [KIND_W-1:0]    okind_r;
  logic [KEY_W-1:0]     okey_r;
  logic [IFACE_W-1:0]   oiface_r;
  logic                 olast_r;
  logic                 out_load;

  logic                 hash_start, hash_done;
  logic [KEY_W-1:0]     hkey;
  logic [KEY_W-1:0]     key_r;

  entry_t               ring [TABLE_DEPTH];
  entry_t               head, tail_in;
  logic                 shift_en;
  logic                 out_free, in_xfer;
  logic                 rel, hit, fre, emit, step;

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_BLOCK_DURATION) ? {16'd0, dur_r} : 32'd0;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign hash_start = in_xfer && !in_ch.mode && in_ch.matched;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DURATION_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_BLOCK_DURATION) begin
      dur_r <= pwdata[DUR_W-1:0];
    end
  end

  fblx_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_start),
    .src_addr (in_ch.src_addr),
    .dst_addr (in_ch.dst_addr),
    .dst_port (in_ch.dst_port),
    .protocol (in_ch.protocol),
    .done     (hash_done),
    .key      (hkey)
  );

  assign head = ring[0];

  always_comb begin
    rel  = (head.key != '0) && (head.expiry <= {1'b0, now_r});
    hit  = !found_r && (head.key == key_r);
    fre  = !found_r && !hit && ((head.key == '0) || (head.expiry < {1'b0, now_r}));
    emit = mode_r && rel;
    step = (state_r == S_SCAN) && (!emit || out_free);
    tail_in = head;
    if (mode_r) begin
      if (rel) tail_in = '0;
    end else if (hit) begin
      tail_in.expiry = exp_r;
    end else if (fre) begin
      tail_in = '{key: key_r, expiry: exp_r, iface: iface_r};
    end
  end

  assign shift_en = step;

  assign out_load = (in_xfer && !in_ch.mode && !in_ch.matched) ||
                    ((state_r == S_SCAN) && step && emit) ||
                    ((state_r == S_DONE) && out_free);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    fblx_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .entry_in  ((i == TABLE_DEPTH - 1) ? tail_in : ring[(i + 1) % TABLE_DEPTH]),
      .entry_out (ring[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && !out_load) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mode_r  <= in_ch.mode;
            now_r   <= in_ch.now_seconds;
            iface_r <= in_ch.iface_index;
            exp_r   <= {1'b0, in_ch.now_seconds} + {17'd0, dur_r};
            found_r <= 1'b0;
            cnt_r   <= '0;
            if (in_ch.mode) begin
              state_r <= S_SCAN;
            end else if (in_ch.matched) begin
              state_r <= S_HASH;
            end else begin
              ov_r     <= 1'b1;
              okind_r  <= KIND_IGNORED;
              okey_r   <= '0;
              oiface_r <= '0;
              olast_r  <= 1'b1;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            key_r   <= hkey;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step) begin
            if (emit) begin
              ov_r     <= 1'b1;
              okind_r  <= KIND_RELEASED;
              okey_r   <= head.key;
              oiface_r <= head.iface;
              olast_r  <= 1'b0;
            end
            if (!mode_r && hit) begin
              found_r <= 1'b1;
              kind_r  <= KIND_REFRESHED;
            end else if (!mode_r && fre) begin
              found_r <= 1'b1;
              kind_r  <= KIND_INSERTED;
            end
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            olast_r  <= 1'b1;
            oiface_r <= '0;
            if (mode_r) begin
              okind_r <= KIND_SWEEP_DONE;
              okey_r  <= '0;
            end else begin
              okind_r <= found_r ? kind_r : KIND_FULL;
              okey_r  <= key_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.kind      = okind_r;
  assign out_ch.flow_key  = okey_r;
  assign out_ch.out_iface = oiface_r;
  assign out_ch.last      = olast_r;

endmodule

`default_nettype wire
